// File: design/bpe_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and the exp2 root table of the bit posterior expectation block.
package bpe_pkg;

	localparam int NUM_POS   = 8;
	localparam int IDX_W     = 4;
	localparam int LR_W      = 16;
	localparam int FRAC_BITS = 12;
	localparam int STEP_W    = 4;
	localparam int SAT_LIMIT = 17;
	localparam int LIM_Q12   = SAT_LIMIT << FRAC_BITS;
	localparam int MUL_W     = 32;
	localparam int PROD_W    = 64;
	localparam int EXP_W     = 6;
	localparam int DVD_W     = 64;
	localparam int DVS_W     = 49;
	localparam int QUO_W     = 17;
	localparam int SUM_W     = 24;

	localparam logic [MUL_W-1:0] ONE_Q30 = 32'h4000_0000;
	localparam logic [QUO_W-1:0] ONE_Q16 = 17'h1_0000;
	localparam logic [SUM_W-1:0] SUM_MAX = 24'hFF_FFFF;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PROD,
		ST_CLASS,
		ST_EXP,
		ST_DEN,
		ST_DIV,
		ST_ACC
	} bpe_state_t;

	// Root k of two in Q2.30: r0 = 2.0 and every further root is the integer square
	// root of the previous one scaled by 2^30. Only evaluated at elaboration.
	function automatic logic [MUL_W-1:0] exp2_root(input int k);
		logic [63:0] r;
		logic [63:0] v;
		logic [63:0] res;
		logic [63:0] b;
		r = 64'd1 << 31;
		for (int i = 1; i <= k; i++) begin
			v   = r << 30;
			res = '0;
			b   = 64'd1 << 62;
			while (b > v)
				b = b >> 2;
			while (b != 0) begin
				if (v >= res + b) begin
					v   = v - (res + b);
					res = (res >> 1) + b;
				end else begin
					res = res >> 1;
				end
				b = b >> 2;
			end
			r = res;
		end
		return r[MUL_W-1:0];
	endfunction

	localparam logic [MUL_W-1:0] ROOT_Q30 [FRAC_BITS] = '{
		exp2_root(1), exp2_root(2), exp2_root(3), exp2_root(4),
		exp2_root(5), exp2_root(6), exp2_root(7), exp2_root(8),
		exp2_root(9), exp2_root(10), exp2_root(11), exp2_root(12)
	};

endpackage

// File: design/bpe_if.sv
`timescale 1ns / 1ps
// Handshake interfaces for the bit item, result and register write channels.
interface bpe_item_if #(parameter int COUNT_BITS = 16);
	logic                  valid;
	logic                  ready;
	logic [COUNT_BITS-1:0] zero_count;
	logic [COUNT_BITS-1:0] one_count;
	logic [2:0]            bit_pos;
	logic                  last_bit;

	modport source (output valid, zero_count, one_count, bit_pos, last_bit, input ready);
	modport sink   (input valid, zero_count, one_count, bit_pos, last_bit, output ready);
endinterface

interface bpe_result_if;
	logic        valid;
	logic        ready;
	logic [23:0] expected_value;

	modport source (output valid, expected_value, input ready);
	modport sink   (input valid, expected_value, output ready);
endinterface

interface bpe_cfg_if;
	logic        valid;
	logic        ready;
	logic [3:0]  index;
	logic [15:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// File: design/bpe_mult.sv
`timescale 1ns / 1ps
// Shared 32 by 32 unsigned multiplier with a registered product.
module bpe_mult (
	input  logic                  clk,
	input  logic [bpe_pkg::MUL_W-1:0]  a,
	input  logic [bpe_pkg::MUL_W-1:0]  b,
	output logic [bpe_pkg::PROD_W-1:0] p
);
	import bpe_pkg::*;

	logic [PROD_W-1:0] p_s1;

	always_ff @(posedge clk) begin
		p_s1 <= PROD_W'(a) * PROD_W'(b);
	end

	assign p = p_s1;
endmodule

// File: design/bpe_divider.sv
`timescale 1ns / 1ps
// Restoring divider giving one quotient bit per cycle for the posterior probability.
module bpe_divider (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [bpe_pkg::DVD_W-1:0]  dividend,
	input  logic [bpe_pkg::DVS_W-1:0]  divisor,
	output logic                       done,
	output logic [bpe_pkg::QUO_W-1:0]  quotient
);
	import bpe_pkg::*;

	localparam int CNT_W = $clog2(QUO_W);

	logic [DVD_W-1:0] rem_q;
	logic [DVD_W:0]   dvs_q;
	logic [QUO_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic             fits;

	assign fits = {1'b0, rem_q} >= dvs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(QUO_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0)
					busy_q <= 1'b0;
				else
					cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// The divisor starts aligned to the top quotient bit and walks down one place a step.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			dvs_q <= {divisor, (QUO_W - 1)'(0)};
		end else if (busy_q) begin
			if (fits)
				rem_q <= rem_q - dvs_q[DVD_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], fits};
			dvs_q <= dvs_q >> 1;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

// File: design/bit_posterior_expectation.sv
`timescale 1ns / 1ps
// Top level of the bit posterior expectation block: sequencer, registers and Horner sum.
//
//  Channel   Modport  Handshake     Carries
//  item      sink     valid/ready   zero_count, one_count, bit_pos, last_bit
//  result    source   valid/ready   expected_value (unsigned Q8.16)
//  cfg       sink     valid/ready   index, data (log ratio per bit position, Q4.12)
//
// A bit goes through the product, its class, the root products of 2^frac on the
// shared multiplier, the restoring divider with one quotient bit a cycle, and the
// accumulate step; a bit whose exponent saturates skips the root products and the
// divider. A new request is taken only once the bit before it is done.
// Reset clears the log ratio registers, the running sum and all control state.
// A finished result waits in the output register while the next bit is taken; only
// a last bit that finds that register full and unread holds in the accumulate step.
module bit_posterior_expectation #(
	parameter int MAX_BITS   = 8,
	parameter int COUNT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	bpe_item_if.sink    item,
	bpe_result_if.source result,
	bpe_cfg_if.sink     cfg
);
	import bpe_pkg::*;

	// Sequencer state.
	bpe_state_t state_q;
	bpe_state_t state_d;

	// Log ratio registers, one per bit position.
	logic [LR_W-1:0] lr_q [NUM_POS];

	// Operands and facts of the bit at work.
	logic [COUNT_BITS-1:0] mag_a_q;
	logic [LR_W-1:0]       mag_b_q;
	logic                  neg_q;
	logic                  last_q;
	logic [EXP_W-1:0]      n_q;
	logic [FRAC_BITS-1:0]  f_q;
	logic [STEP_W-1:0]     step_q;
	logic [QUO_W-1:0]      p1_q;

	// Running sum and the output register.
	logic [SUM_W-1:0] acc_q;
	logic [SUM_W-1:0] res_data_q;
	logic             res_valid_q;

	// Shared units.
	logic [MUL_W-1:0]  mul_a;
	logic [MUL_W-1:0]  mul_b;
	logic [PROD_W-1:0] mul_p;
	logic              div_start;
	logic              div_done;
	logic [QUO_W-1:0]  div_quo;
	logic [DVD_W-1:0]  div_dvd;
	logic [DVS_W-1:0]  div_dvs;

	logic                  item_rdy;
	logic                  item_take;
	logic                  acc_fire;
	logic [COUNT_BITS-1:0] zc;
	logic [COUNT_BITS-1:0] oc;
	logic [COUNT_BITS:0]   d_s;
	logic [COUNT_BITS:0]   d_neg;
	logic [LR_W-1:0]       lr_sel;
	logic [LR_W-1:0]       lr_neg;
	logic                  sat_zero;
	logic                  sat_one;
	logic [17:0]           x_mag;
	logic [17:0]           x_s;
	logic [STEP_W-1:0]     fbit_idx;
	logic                  n_neg;
	logic [EXP_W-1:0]      n_abs;
	logic [EXP_W-1:0]      n_neg_val;
	logic [63:0]           den64;
	logic [63:0]           num64;
	logic [SUM_W+1:0]      sum_wide;
	logic [SUM_W-1:0]      sum_sat;

	bpe_mult u_mult (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	bpe_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign item.ready            = item_rdy;
	assign item_take             = item.valid && item_rdy;
	assign cfg.ready             = 1'b1;
	assign result.valid          = res_valid_q;
	assign result.expected_value = res_data_q;

	// The count difference and the log ratio go to the multiplier as magnitudes;
	// the sign of their product is kept on the side.
	assign zc     = item.zero_count;
	assign oc     = item.one_count;
	assign d_s    = {1'b0, zc} - {1'b0, oc};
	assign d_neg  = -d_s;
	assign lr_sel = ({1'b0, item.bit_pos} < IDX_W'(MAX_BITS)) ? lr_q[item.bit_pos] : '0;
	assign lr_neg = -lr_sel;

	// Saturation of the exponent. A positive exponent of 17.0 or more gives a
	// posterior of zero, a negative one below -17.0 gives exactly one.
	assign sat_zero = !neg_q && (mul_p >= PROD_W'(LIM_Q12));
	assign sat_one  = neg_q && (mul_p > PROD_W'(LIM_Q12));

	// Inside the limits the exponent fits 18 bits; its top bits are the integer
	// part rounded down and the low twelve the fraction.
	assign x_mag = {1'b0, mul_p[16:0]};
	assign x_s   = neg_q ? (18'd0 - x_mag) : x_mag;

	assign fbit_idx = STEP_W'(FRAC_BITS - 1) - step_q;

	// Denominator 1 + 2^x and numerator 2^16, both held in Q.30; for a negative
	// integer part both are scaled up instead of shifting the mantissa right.
	assign n_neg     = n_q[EXP_W-1];
	assign n_neg_val = -n_q;
	assign n_abs     = n_neg ? n_neg_val : n_q;

	always_comb begin
		if (n_neg) begin
			den64 = (64'd1 << (EXP_W'(30) + n_abs)) + 64'(mul_p[61:30]);
			num64 = 64'd1 << (EXP_W'(46) + n_abs);
		end else begin
			den64 = (64'd1 << 30) + (64'(mul_p[61:30]) << n_abs);
			num64 = 64'd1 << 46;
		end
	end

	// Rounding half up is folded into the dividend as half the divisor.
	assign div_dvd = num64 + (den64 >> 1);
	assign div_dvs = den64[DVS_W-1:0];

	// Horner step with saturation at the top of Q8.16.
	assign sum_wide = {1'b0, acc_q, 1'b0} + (SUM_W + 2)'(p1_q);
	assign sum_sat  = (sum_wide > (SUM_W + 2)'(SUM_MAX)) ? SUM_MAX : sum_wide[SUM_W-1:0];

	assign acc_fire = (state_q == ST_ACC) && (!last_q || !res_valid_q || result.ready);

	always_comb begin
		state_d   = state_q;
		mul_a     = '0;
		mul_b     = '0;
		div_start = 1'b0;
		item_rdy  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				item_rdy = 1'b1;
				if (item.valid)
					state_d = ST_PROD;
			end
			ST_PROD: begin
				mul_a   = MUL_W'(mag_a_q);
				mul_b   = MUL_W'(mag_b_q);
				state_d = ST_CLASS;
			end
			ST_CLASS: begin
				state_d = (sat_zero || sat_one) ? ST_ACC : ST_EXP;
			end
			ST_EXP: begin
				// Each step multiplies the previous product by the root for one
				// fraction bit, or by one where that bit is clear.
				mul_a = (step_q == '0) ? ONE_Q30 : mul_p[61:30];
				mul_b = f_q[fbit_idx] ? ROOT_Q30[step_q] : ONE_Q30;
				if (step_q == STEP_W'(FRAC_BITS - 1))
					state_d = ST_DEN;
			end
			ST_DEN: begin
				div_start = 1'b1;
				state_d   = ST_DIV;
			end
			ST_DIV: begin
				if (div_done)
					state_d = ST_ACC;
			end
			ST_ACC: begin
				if (acc_fire)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
			acc_q       <= '0;
			for (int i = 0; i < NUM_POS; i++)
				lr_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (cfg.valid && (cfg.index < IDX_W'(NUM_POS)))
				lr_q[cfg.index[2:0]] <= cfg.data;
			// A new result may replace one that leaves in the same cycle.
			if (acc_fire && last_q)
				res_valid_q <= 1'b1;
			else if (res_valid_q && result.ready)
				res_valid_q <= 1'b0;
			if (acc_fire) begin
				if (last_q)
					acc_q <= '0;
				else
					acc_q <= sum_sat;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_take) begin
			mag_a_q <= d_s[COUNT_BITS] ? d_neg[COUNT_BITS-1:0] : d_s[COUNT_BITS-1:0];
			mag_b_q <= lr_sel[LR_W-1] ? lr_neg : lr_sel;
			neg_q   <= d_s[COUNT_BITS] ^ lr_sel[LR_W-1];
			last_q  <= item.last_bit;
		end
		if (state_q == ST_CLASS) begin
			n_q    <= x_s[17:FRAC_BITS];
			f_q    <= x_s[FRAC_BITS-1:0];
			step_q <= '0;
			p1_q   <= sat_one ? ONE_Q16 : '0;
		end
		if (state_q == ST_EXP)
			step_q <= step_q + 1'b1;
		if ((state_q == ST_DIV) && div_done)
			p1_q <= div_quo;
		if (acc_fire && last_q)
			res_data_q <= sum_sat;
	end
endmodule
